FILE: rtl/bif_pkg.sv
// Shared constants, types and constant functions for the bilateral image filter.
`default_nettype none

package bif_pkg;

    // Default build parameters
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int RADIUS_DEF      = 2;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam int MAX_HEIGHT = 4096;

    // Pixel and arithmetic widths fixed by the field formats
    localparam int CHAN_W = 8;
    localparam int RGB_W  = 24;
    localparam int SUM_W  = 10;          // R+G+B
    localparam int SQ_W   = 20;          // d*d
    localparam int RNG_W  = 28;          // (d*d*range_coef) >> 16
    localparam int SPT_W  = 26;          // s*spatial_coef, s up to 32
    localparam int S_W    = 6;           // dx*dx+dy*dy for radius up to 4
    localparam int T_W    = 29;
    localparam int U_W    = 46;
    localparam int K_W    = 14;
    localparam int F_W    = 16;
    localparam int Q_W    = 31;          // Q30 value up to 1.0
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_COEF   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPATIAL_COEF = 2'd3;

    localparam logic [10:0] IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd480;
    localparam logic [23:0] RANGE_COEF_RST   = 24'd2386093;
    localparam logic [19:0] SPATIAL_COEF_RST = 20'd8192;

    // Word handed from cell to cell along the exponent chain
    typedef struct packed {
        logic             live;
        logic             in_frame;
        logic [K_W-1:0]   k;
        logic [F_W-1:0]   f;
        logic [RGB_W-1:0] rgb;
    } weight_word_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bt;
        v   = v_in;
        res = 64'd0;
        bt  = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (bt > v)
            begin
                bt = bt >> 2;
            end
        end
        for (int i = 0; i < 32; i++)
        begin
            if (bt != 64'd0)
            begin
                if (v >= res + bt)
                begin
                    v   = v - (res + bt);
                    res = (res >> 1) + bt;
                end
                else
                begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
        end
        return res;
    endfunction

    // Q30 value of 2^(-2^(b-16))
    function automatic logic [Q_W-1:0] pow_const(input int b);
        logic [63:0] c;
        c = isqrt64(64'd1 << 59);
        for (int j = 14; j >= 0; j--)
        begin
            if (j >= b)
            begin
                c = isqrt64(c << 30);
            end
        end
        return c[Q_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bif_pow_cell.sv
// One cell of the exponent chain: multiply by 2^(-2^(BIT-16)) when its fraction bit is set.
`default_nettype none

module bif_pow_cell #(
    parameter int BIT = 0
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [bif_pkg::Q_W-1:0] r_in,
    input  wire bif_pkg::weight_word_t side_in,
    output logic [bif_pkg::Q_W-1:0]    r_out,
    output bif_pkg::weight_word_t      side_out
);

    localparam logic [bif_pkg::Q_W-1:0] FACTOR = bif_pkg::pow_const(BIT);

    logic [61:0]               prod;
    logic [61:0]               prod_round;
    logic [bif_pkg::Q_W-1:0]   r_next;
    logic [bif_pkg::Q_W-1:0]   r_reg;
    bif_pkg::weight_word_t     side_reg;
    logic                      live_reg;

    assign prod       = 62'(r_in) * 62'(FACTOR);
    assign prod_round = prod + (62'd1 << 29);
    assign r_next     = side_in.f[BIT] ? prod_round[60:30] : r_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
        end
        else
        begin
            live_reg <= side_in.live;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        side_reg <= side_in;
    end

    always_comb
    begin
        side_out      = side_reg;
        side_out.live = live_reg;
    end

    assign r_out = r_reg;

endmodule

`default_nettype wire

FILE: rtl/bif_divider.sv
// Three-lane restoring divider for the rounded channel means, one quotient bit a cycle.
`default_nettype none

module bif_divider #(
    parameter int NUM_W  = 42,
    parameter int NORM_W = 22
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [2:0][NUM_W-1:0]  num,
    input  wire logic [NORM_W-1:0]      den,
    output logic                        done,
    output logic [2:0][7:0]             quot
);

    localparam int QB = 9;

    logic [2:0][NUM_W-1:0] rem_reg, rem_next;
    logic [2:0][QB-1:0]    q_reg, q_next;
    logic [NUM_W-1:0]      dsh_reg, dsh_next;
    logic                  zero_reg, zero_next;
    logic [3:0]            step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        dsh_next  = dsh_reg;
        zero_next = zero_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            q_next    = '0;
            dsh_next  = NUM_W'(den) << (QB - 1);
            zero_next = (den == '0);
            step_next = 4'(QB - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (rem_reg[i] >= dsh_reg)
                begin
                    rem_next[i] = rem_reg[i] - dsh_reg;
                    q_next[i]   = {q_reg[i][QB-2:0], 1'b1};
                end
                else
                begin
                    q_next[i] = {q_reg[i][QB-2:0], 1'b0};
                end
            end
            dsh_next  = dsh_reg >> 1;
            step_next = step_reg - 4'd1;
            if (step_reg == 4'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        dsh_reg  <= dsh_next;
        zero_reg <= zero_next;
        step_reg <= step_next;
    end

    // saturate at full scale, zero weight sum gives black
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (zero_reg)
            begin
                quot[i] = 8'd0;
            end
            else if (q_reg[i][QB-1])
            begin
                quot[i] = 8'hFF;
            end
            else
            begin
                quot[i] = q_reg[i][7:0];
            end
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

FILE: rtl/bilateral_image_filter_core.sv
// Top level of the streaming bilateral image filter.
// Pixels arrive in raster order; each output pixel is the range- and space-weighted mean of
// the in-frame pixels of a (2*RADIUS+1)^2 window around it, and appears once the input has
// run RADIUS rows and RADIUS pixels ahead of it; flush words (op = 1) drain the frame tail
// after the last pixel. A word that yields no output leaves the input ready. A word that yields
// an output holds the input until that output is loaded into the output register: the window
// is read one neighbor a cycle through the single read port of the line store, each neighbor
// then goes through a 16-cell exponent chain, and a three-lane divider forms the channel means.
// The output register must be free before the next output is loaded, so a stalled output
// holds the input longer.
// A new word is taken while the previous output still waits at the output register.
// The line store holds 3*RADIUS+1 rows and needs no clearing after reset.
`default_nettype none

module bilateral_image_filter_core #(
    parameter int MAX_WIDTH   = bif_pkg::MAX_WIDTH_DEF,
    parameter int RADIUS      = bif_pkg::RADIUS_DEF,
    parameter int WEIGHT_BITS = bif_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [bif_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bif_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              op,
    input  wire logic [7:0]                        in_red,
    input  wire logic [7:0]                        in_green,
    input  wire logic [7:0]                        in_blue,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [7:0]                             out_red,
    output logic [7:0]                             out_green,
    output logic [7:0]                             out_blue,
    output logic                                   last_of_frame
);

    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int RING     = 3 * RADIUS + 1;
    localparam int RW       = $clog2(RING);
    localparam int AW       = RW + CW;
    localparam int DEPTH    = RING * (1 << CW);
    localparam int SPAN     = 2 * RADIUS + 1;
    localparam int OFF_W    = $clog2(SPAN);
    localparam int NB       = SPAN * SPAN;
    localparam int CNT_W    = $clog2(NB + 1);
    localparam int WT_W     = WEIGHT_BITS + 1;
    localparam int NORM_W   = WT_W + $clog2(NB);
    localparam int ACC_W    = NORM_W + 8;
    localparam int NUM_W    = ACC_W + 1;
    localparam int PROD_W   = WT_W + 8;
    localparam int CELLS    = bif_pkg::F_W;
    localparam int LIN_W    = 25;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CENTRE = 3'd1;
    localparam logic [2:0] S_CSUM   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    // ---------------------------------------------------------------- configuration
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [23:0] range_reg;
    logic [19:0] spatial_reg;
    logic        restart;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= bif_pkg::IMAGE_WIDTH_RST;
            height_reg  <= bif_pkg::IMAGE_HEIGHT_RST;
            range_reg   <= bif_pkg::RANGE_COEF_RST;
            spatial_reg <= bif_pkg::SPATIAL_COEF_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bif_pkg::REG_IMAGE_WIDTH:  width_reg   <= cfg_data[10:0];
                bif_pkg::REG_IMAGE_HEIGHT: height_reg  <= cfg_data[12:0];
                bif_pkg::REG_RANGE_COEF:   range_reg   <= cfg_data[23:0];
                bif_pkg::REG_SPATIAL_COEF: spatial_reg <= cfg_data[19:0];
                default:                   width_reg   <= width_reg;
            endcase
        end
    end

    assign restart = cfg_write && (cfg_index == bif_pkg::REG_IMAGE_WIDTH ||
                                   cfg_index == bif_pkg::REG_IMAGE_HEIGHT);

    logic [10:0] w;
    logic [12:0] h;

    always_comb
    begin
        if (width_reg == 11'd0)
        begin
            w = 11'd1;
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w = 11'(MAX_WIDTH);
        end
        else
        begin
            w = width_reg;
        end
        if (height_reg == 13'd0)
        begin
            h = 13'd1;
        end
        else if (32'(height_reg) > bif_pkg::MAX_HEIGHT)
        begin
            h = 13'(bif_pkg::MAX_HEIGHT);
        end
        else
        begin
            h = height_reg;
        end
    end

    // ---------------------------------------------------------------- frame counters
    logic [2:0]       state_reg, state_next;
    logic [CW-1:0]    in_col_reg, in_col_next;
    logic [12:0]      in_row_reg, in_row_next;
    logic [RW-1:0]    in_ring_reg, in_ring_next;
    logic [LIN_W-1:0] in_cnt_reg, in_cnt_next;
    logic [CW-1:0]    out_col_reg, out_col_next;
    logic [11:0]      out_row_reg, out_row_next;
    logic [RW-1:0]    out_ring_reg, out_ring_next;
    logic [LIN_W-1:0] out_cnt_reg, out_cnt_next;

    logic [CW-1:0]    cur_col_reg, cur_col_next;
    logic [11:0]      cur_row_reg, cur_row_next;
    logic [RW-1:0]    cur_ring_reg, cur_ring_next;
    logic             cur_last_reg, cur_last_next;

    logic             accept;
    logic             complete;
    logic             px_write;
    logic             emit;
    logic             is_last;
    logic [15:0]      col_inc, ocol_inc, lat;
    logic [12:0]      row_after;
    logic [LIN_W-1:0] cnt_after;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign complete = (in_row_reg >= h);
    assign px_write = accept && !op && !complete;
    assign col_inc  = 16'(in_col_reg) + 16'd1;
    assign ocol_inc = 16'(out_col_reg) + 16'd1;
    assign lat      = 16'(RADIUS) * 16'(w) + 16'(RADIUS);
    assign is_last  = (13'(out_row_reg) == h - 13'd1) && (16'(out_col_reg) == 16'(w) - 16'd1);
    assign row_after = (col_inc >= 16'(w)) ? in_row_reg + 13'd1 : in_row_reg;
    assign cnt_after = in_cnt_reg + LIN_W'(1);

    always_comb
    begin
        if (!op && !complete)
        begin
            emit = (row_after >= h) ||
                   (cnt_after > out_cnt_reg + LIN_W'(lat));
        end
        else
        begin
            emit = complete;
        end
    end

    // ---------------------------------------------------------------- scan control
    logic [OFF_W-1:0] oy_reg, oy_next, ox_reg, ox_next;
    logic [CNT_W-1:0] acc_cnt_reg;
    logic             div_start;
    logic             div_done;

    assign div_start = (state_reg == S_DRAIN) && (acc_cnt_reg == CNT_W'(NB));

    always_comb
    begin
        state_next    = state_reg;
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_ring_next  = in_ring_reg;
        in_cnt_next   = in_cnt_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_ring_next = out_ring_reg;
        out_cnt_next  = out_cnt_reg;
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;
        cur_ring_next = cur_ring_reg;
        cur_last_next = cur_last_reg;
        oy_next       = oy_reg;
        ox_next       = ox_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (px_write)
                    begin
                        in_cnt_next = cnt_after;
                        if (col_inc >= 16'(w))
                        begin
                            in_col_next  = '0;
                            in_row_next  = in_row_reg + 13'd1;
                            in_ring_next = (32'(in_ring_reg) == RING - 1) ?
                                           '0 : in_ring_reg + RW'(1);
                        end
                        else
                        begin
                            in_col_next = CW'(col_inc);
                        end
                    end
                    if (emit)
                    begin
                        cur_col_next  = out_col_reg;
                        cur_row_next  = out_row_reg;
                        cur_ring_next = out_ring_reg;
                        cur_last_next = is_last;
                        state_next    = S_CENTRE;
                        if (is_last)
                        begin
                            in_col_next   = '0;
                            in_row_next   = '0;
                            in_ring_next  = '0;
                            in_cnt_next   = '0;
                            out_col_next  = '0;
                            out_row_next  = '0;
                            out_ring_next = '0;
                            out_cnt_next  = '0;
                        end
                        else
                        begin
                            out_cnt_next = out_cnt_reg + LIN_W'(1);
                            if (ocol_inc >= 16'(w))
                            begin
                                out_col_next  = '0;
                                out_row_next  = out_row_reg + 12'd1;
                                out_ring_next = (32'(out_ring_reg) == RING - 1) ?
                                                '0 : out_ring_reg + RW'(1);
                            end
                            else
                            begin
                                out_col_next = CW'(ocol_inc);
                            end
                        end
                    end
                end
            end
            S_CENTRE:
            begin
                state_next = S_CSUM;
            end
            S_CSUM:
            begin
                oy_next    = '0;
                ox_next    = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (32'(ox_reg) == SPAN - 1)
                begin
                    ox_next = '0;
                    oy_next = oy_reg + OFF_W'(1);
                    if (32'(oy_reg) == SPAN - 1)
                    begin
                        state_next = S_DRAIN;
                    end
                end
                else
                begin
                    ox_next = ox_reg + OFF_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (div_start)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // frame geometry change starts the frame over
        if (restart)
        begin
            in_col_next   = '0;
            in_row_next   = '0;
            in_ring_next  = '0;
            in_cnt_next   = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            out_ring_next = '0;
            out_cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_ring_reg  <= '0;
            in_cnt_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_ring_reg <= '0;
            out_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_ring_reg  <= in_ring_next;
            in_cnt_reg   <= in_cnt_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_ring_reg <= out_ring_next;
            out_cnt_reg  <= out_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_col_reg  <= cur_col_next;
        cur_row_reg  <= cur_row_next;
        cur_ring_reg <= cur_ring_next;
        cur_last_reg <= cur_last_next;
        oy_reg       <= oy_next;
        ox_reg       <= ox_next;
    end

    // ---------------------------------------------------------------- neighbor address
    logic [15:0]      ys, xs;
    logic             nb_in_frame;
    logic [7:0]       ring_sum, ring_red1, ring_red2;
    logic [RW-1:0]    nb_ring;
    logic [CW-1:0]    nb_col;
    logic [OFF_W-1:0] dya, dxa;
    logic [bif_pkg::S_W-1:0] nb_s;
    logic [AW-1:0]    rd_addr;

    assign ys = 16'(cur_row_reg) + 16'(oy_reg);
    assign xs = 16'(cur_col_reg) + 16'(ox_reg);
    assign nb_in_frame = (ys >= 16'(RADIUS)) && (ys - 16'(RADIUS) < 16'(h)) &&
                         (xs >= 16'(RADIUS)) && (xs - 16'(RADIUS) < 16'(w));
    assign nb_col = CW'(xs - 16'(RADIUS));

    assign ring_sum  = 8'(cur_ring_reg) + 8'(oy_reg) + 8'(RING - RADIUS);
    assign ring_red1 = (ring_sum >= 8'(RING)) ? ring_sum - 8'(RING) : ring_sum;
    assign ring_red2 = (ring_red1 >= 8'(RING)) ? ring_red1 - 8'(RING) : ring_red1;
    assign nb_ring   = RW'(ring_red2);

    assign dya  = (32'(oy_reg) >= RADIUS) ? oy_reg - OFF_W'(RADIUS) : OFF_W'(RADIUS) - oy_reg;
    assign dxa  = (32'(ox_reg) >= RADIUS) ? ox_reg - OFF_W'(RADIUS) : OFF_W'(RADIUS) - ox_reg;
    assign nb_s = bif_pkg::S_W'(dya) * bif_pkg::S_W'(dya) +
                  bif_pkg::S_W'(dxa) * bif_pkg::S_W'(dxa);

    assign rd_addr = (state_reg == S_CENTRE) ? {cur_ring_reg, cur_col_reg} : {nb_ring, nb_col};

    // ---------------------------------------------------------------- line store
    logic [bif_pkg::RGB_W-1:0] line_mem [0:DEPTH-1];
    logic [bif_pkg::RGB_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (px_write)
        begin
            line_mem[{in_ring_reg, in_col_reg}] <= {in_red, in_green, in_blue};
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= line_mem[rd_addr];
    end

    function automatic logic [bif_pkg::SUM_W-1:0] chan_sum(input logic [23:0] p);
        return bif_pkg::SUM_W'(p[23:16]) + bif_pkg::SUM_W'(p[15:8]) +
               bif_pkg::SUM_W'(p[7:0]);
    endfunction

    // ---------------------------------------------------------------- weight pipeline
    logic [bif_pkg::SUM_W-1:0] csum_reg;
    logic                      v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v6_reg, v7_reg;
    logic                      f0_reg, f1_reg, f2_reg, f3_reg, f4_reg;
    logic [bif_pkg::S_W-1:0]   s0_reg, s1_reg, s2_reg;
    logic [23:0]               q1_reg, q2_reg, q3_reg, q4_reg, q6_reg;
    logic [bif_pkg::SUM_W-1:0] d1_reg, qs0;
    logic [bif_pkg::SQ_W-1:0]  sq2_reg;
    logic [bif_pkg::RNG_W-1:0] rng3_reg;
    logic [bif_pkg::SPT_W-1:0] spt3_reg;
    logic [bif_pkg::T_W-1:0]   t4_reg;
    logic [43:0]               rng_full;
    logic [bif_pkg::U_W-1:0]   u_full;

    assign qs0      = chan_sum(rd_data_reg);
    assign rng_full = 44'(sq2_reg) * 44'(range_reg);
    assign u_full   = bif_pkg::U_W'(t4_reg) * bif_pkg::U_W'(bif_pkg::LOG2E_Q16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= (state_reg == S_SCAN);
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CSUM)
        begin
            csum_reg <= qs0;
        end
        f0_reg   <= nb_in_frame;
        s0_reg   <= nb_s;
        f1_reg   <= f0_reg;
        s1_reg   <= s0_reg;
        q1_reg   <= rd_data_reg;
        d1_reg   <= (qs0 > csum_reg) ? qs0 - csum_reg : csum_reg - qs0;
        f2_reg   <= f1_reg;
        s2_reg   <= s1_reg;
        q2_reg   <= q1_reg;
        sq2_reg  <= bif_pkg::SQ_W'(d1_reg) * bif_pkg::SQ_W'(d1_reg);
        f3_reg   <= f2_reg;
        q3_reg   <= q2_reg;
        rng3_reg <= rng_full[43:16];
        spt3_reg <= bif_pkg::SPT_W'(s2_reg) * bif_pkg::SPT_W'(spatial_reg);
        f4_reg   <= f3_reg;
        q4_reg   <= q3_reg;
        t4_reg   <= bif_pkg::T_W'(rng3_reg) + bif_pkg::T_W'(spt3_reg);
    end

    // exponent chain: one cell per fraction bit of the base-2 exponent
    logic [bif_pkg::Q_W-1:0] r_chain [0:CELLS];
    bif_pkg::weight_word_t   side_chain [0:CELLS];
    logic [bif_pkg::Q_W-1:0] r_head_reg;
    bif_pkg::weight_word_t   side_head_reg;
    logic                    head_live_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_live_reg <= 1'b0;
        end
        else
        begin
            head_live_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r_head_reg             <= bif_pkg::Q_W'(1) << 30;
        side_head_reg.live     <= v4_reg;
        side_head_reg.in_frame <= f4_reg;
        side_head_reg.k        <= u_full[45:32];
        side_head_reg.f        <= u_full[31:16];
        side_head_reg.rgb      <= q4_reg;
    end

    always_comb
    begin
        r_chain[0]         = r_head_reg;
        side_chain[0]      = side_head_reg;
        side_chain[0].live = head_live_reg;
    end

    for (genvar b = 0; b < CELLS; b++)
    begin : g_cell
        bif_pow_cell #(
            .BIT(b)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .r_in    (r_chain[b]),
            .side_in (side_chain[b]),
            .r_out   (r_chain[b+1]),
            .side_out(side_chain[b+1])
        );
    end

    // scale Q30 power down to weight, rounding half up
    logic [14:0]      shamt;
    logic [31:0]      round_sum;
    logic [WT_W-1:0]  wt_calc;
    logic [WT_W-1:0]  wt6_reg, wt7_reg;
    logic [PROD_W-1:0] pr7_reg, pg7_reg, pb7_reg;

    assign shamt     = 15'(side_chain[CELLS].k) + 15'(30 - WEIGHT_BITS);
    assign round_sum = 32'(r_chain[CELLS]) + (32'd1 << (shamt[4:0] - 5'd1));

    always_comb
    begin
        if (!side_chain[CELLS].in_frame || shamt >= 15'd32)
        begin
            wt_calc = '0;
        end
        else
        begin
            wt_calc = WT_W'(round_sum >> shamt[4:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            v6_reg <= side_chain[CELLS].live;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        wt6_reg <= wt_calc;
        q6_reg  <= side_chain[CELLS].rgb;
        wt7_reg <= wt6_reg;
        pr7_reg <= PROD_W'(wt6_reg) * PROD_W'(q6_reg[23:16]);
        pg7_reg <= PROD_W'(wt6_reg) * PROD_W'(q6_reg[15:8]);
        pb7_reg <= PROD_W'(wt6_reg) * PROD_W'(q6_reg[7:0]);
    end

    // ---------------------------------------------------------------- accumulate
    logic [ACC_W-1:0]  acc_r_reg, acc_g_reg, acc_b_reg;
    logic [NORM_W-1:0] norm_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CENTRE)
        begin
            acc_r_reg   <= '0;
            acc_g_reg   <= '0;
            acc_b_reg   <= '0;
            norm_reg    <= '0;
            acc_cnt_reg <= '0;
        end
        else if (v7_reg)
        begin
            acc_r_reg   <= acc_r_reg + ACC_W'(pr7_reg);
            acc_g_reg   <= acc_g_reg + ACC_W'(pg7_reg);
            acc_b_reg   <= acc_b_reg + ACC_W'(pb7_reg);
            norm_reg    <= norm_reg + NORM_W'(wt7_reg);
            acc_cnt_reg <= acc_cnt_reg + CNT_W'(1);
        end
    end

    // ---------------------------------------------------------------- divide
    logic [2:0][NUM_W-1:0] div_num;
    logic [2:0][7:0]       div_quot;
    logic [NUM_W-1:0]      half_norm;

    assign half_norm  = NUM_W'(norm_reg >> 1);
    assign div_num[0] = NUM_W'(acc_r_reg) + half_norm;
    assign div_num[1] = NUM_W'(acc_g_reg) + half_norm;
    assign div_num[2] = NUM_W'(acc_b_reg) + half_norm;

    bif_divider #(
        .NUM_W (NUM_W),
        .NORM_W(NORM_W)
    ) u_divider (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (div_num),
        .den  (norm_reg),
        .done (div_done),
        .quot (div_quot)
    );

    // ---------------------------------------------------------------- output word
    logic       out_valid_reg;
    logic [7:0] out_red_reg, out_green_reg, out_blue_reg;
    logic       out_last_reg;
    logic       out_load;

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_red_reg   <= div_quot[0];
            out_green_reg <= div_quot[1];
            out_blue_reg  <= div_quot[2];
            out_last_reg  <= cur_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_red       = out_red_reg;
    assign out_green     = out_green_reg;
    assign out_blue      = out_blue_reg;
    assign last_of_frame = out_last_reg;

endmodule

`default_nettype wire
